/* src/dosc_pkg.sv */
// Shared types, constants and the option format table for the option stream checker.
// No dependencies; used by dosc_res_fifo and dhcp_option_stream_checker.
`default_nettype none

package dosc_pkg;

    // Special option tags
    localparam logic [7:0] TAG_PAD      = 8'd0;
    localparam logic [7:0] TAG_END      = 8'd255;
    localparam logic [7:0] TAG_OVERLOAD = 8'd52;
    localparam logic [7:0] TAG_MSG_TYPE = 8'd53;

    // Parameter limits
    localparam logic [7:0] OVERLOAD_MAX = 8'd3;
    localparam logic [7:0] MSG_TYPE_MAX = 8'd9;

    // Value bytes gathered into the first word
    localparam int VALUE_BYTES = 4;

    // Default depth of the result queue (must be at least 2)
    localparam int RES_FIFO_DEPTH = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_OVERLOAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALIDATE_ENABLE  = 1'd1;

    // Unit size as a shift: 1, 2, 4 or 8 bytes
    localparam logic [1:0] SH_U1 = 2'd0;
    localparam logic [1:0] SH_U2 = 2'd1;
    localparam logic [1:0] SH_U4 = 2'd2;
    localparam logic [1:0] SH_U8 = 2'd3;

    typedef enum logic [2:0] {
        ST_OK               = 3'd0,
        ST_TRUNCATED        = 3'd1,
        ST_NO_END           = 3'd2,
        ST_BAD_OVERLOAD_LEN = 3'd3,
        ST_BAD_FORMAT       = 3'd4,
        ST_PARAM_RANGE      = 3'd5
    } t_status;

    typedef struct packed {
        logic        known;
        logic [1:0]  shift;
        logic [2:0]  lo;
        logic        hi_one;   // at most one unit; otherwise no upper bound
        logic        sw;
        logic        alert;
    } t_fmt;

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  option_tag;
        logic [7:0]  option_length;
        logic [31:0] first_word;
        logic        format_known;
        logic        is_parameter;
        logic [7:0]  overload_mode;
        t_status     status;
        logic        last_result;
    } t_result;

    function automatic t_fmt f_ent(input logic [1:0] shift, input logic [2:0] lo,
                                   input logic hi_one, input logic sw, input logic alert);
        t_fmt f;
        f.known  = 1'b1;
        f.shift  = shift;
        f.lo     = lo;
        f.hi_one = hi_one;
        f.sw     = sw;
        f.alert  = alert;
        return f;
    endfunction

    // Format table lookup; unknown tags return all zero
    function automatic t_fmt f_fmt_lookup(input logic [7:0] tag);
        t_fmt f;
        f = '0;
        unique case (tag)
            8'd1, 8'd51, 8'd54, 8'd58, 8'd59:
                f = f_ent(SH_U4, 3'd1, 1'b1, 1'b0, 1'b1);
            8'd2, 8'd16, 8'd24, 8'd28, 8'd32, 8'd35, 8'd38, 8'd50:
                f = f_ent(SH_U4, 3'd1, 1'b1, 1'b0, 1'b0);
            8'd3:
                f = f_ent(SH_U4, 3'd1, 1'b0, 1'b0, 1'b1);
            8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11,
            8'd41, 8'd42, 8'd44, 8'd45, 8'd48, 8'd49, 8'd65,
            8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75, 8'd76:
                f = f_ent(SH_U4, 3'd1, 1'b0, 1'b0, 1'b0);
            8'd68:
                f = f_ent(SH_U4, 3'd0, 1'b0, 1'b0, 1'b0);
            8'd12, 8'd14, 8'd15, 8'd17, 8'd18, 8'd40, 8'd43, 8'd47,
            8'd55, 8'd56, 8'd60, 8'd64, 8'd66, 8'd67:
                f = f_ent(SH_U1, 3'd1, 1'b0, 1'b0, 1'b0);
            8'd19, 8'd20, 8'd27, 8'd29, 8'd30, 8'd31, 8'd34, 8'd36, 8'd39:
                f = f_ent(SH_U1, 3'd1, 1'b1, 1'b1, 1'b0);
            8'd23, 8'd37, 8'd46:
                f = f_ent(SH_U1, 3'd1, 1'b1, 1'b0, 1'b0);
            8'd52, 8'd53:
                f = f_ent(SH_U1, 3'd1, 1'b1, 1'b0, 1'b1);
            8'd13, 8'd22, 8'd26, 8'd57:
                f = f_ent(SH_U2, 3'd1, 1'b1, 1'b0, 1'b0);
            8'd25:
                f = f_ent(SH_U2, 3'd1, 1'b0, 1'b0, 1'b0);
            8'd21, 8'd33:
                f = f_ent(SH_U8, 3'd1, 1'b0, 1'b0, 1'b0);
            8'd61:
                f = f_ent(SH_U1, 3'd2, 1'b0, 1'b0, 1'b0);
            8'd121:
                f = f_ent(SH_U1, 3'd5, 1'b0, 1'b0, 1'b0);
            default:
                f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* src/dosc_res_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one a cycle while i_ready is high.
// Depends on dosc_pkg (t_result, RES_FIFO_DEPTH).
`default_nettype none

module dosc_res_fifo #(
    parameter int DEPTH = dosc_pkg::RES_FIFO_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_push,      // bit 1 only with bit 0
    input  wire dosc_pkg::t_result i_data0,
    input  wire dosc_pkg::t_result i_data1,
    output logic                   o_space2,    // room for two more
    output logic                   o_valid,
    input  wire logic              i_ready,
    output dosc_pkg::t_result      o_data
);
    import dosc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   w_wptr1;
    logic            w_pop;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    assign w_pop    = o_valid && i_ready;
    assign w_wptr1  = f_inc(r_wptr);
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rptr];
    assign o_space2 = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_wptr  = i_push[1] ? f_inc(w_wptr1) : (i_push[0] ? w_wptr1 : r_wptr);
        n_rptr  = w_pop ? f_inc(r_rptr) : r_rptr;
        n_count = r_count + CW'(i_push[0]) + CW'(i_push[1]) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push[0]) begin
            r_mem[r_wptr] <= i_data0;
        end
        if (i_push[1]) begin
            r_mem[w_wptr1] <= i_data1;
        end
    end

endmodule

`default_nettype wire

/* src/dhcp_option_stream_checker.sv */
// Top level of the DHCP option stream checker: input register, option parser, checks and result queue.
// Depends on dosc_pkg and dosc_res_fifo.
`default_nettype none

// DHCP option stream checker. Takes one options-buffer byte per transfer on the input
// channel (i_data_byte, with i_end_of_buffer on the last byte) and reports each completed
// option that passes its checks as a record (record_kind 0) and each buffer with one final
// status record (record_kind 1, last_result 1). Pad bytes are skipped, the end tag closes
// the buffer, and every other option is parsed as tag, length, value and, while
// validate_enable is set, checked for known tags against a built-in format table (unit
// size, unit count, switch values), with overload and message type range checks on alert
// tags. After a failing option or the end tag, the rest of the buffer is swallowed.
// Rate: one byte per clock, sustained, as long as results are taken; each byte is captured
// in the input register, parsed in one pass and its results written into the result queue.
// A byte can yield two results (an option record and the missing-end-tag status), and
// the output drains one result per cycle, while i_ready is high, through a RES_DEPTH-entry
// result queue; the input stalls only while that queue has fewer than two free entries.
// Configuration (capture_overload at index 0, validate_enable at index 1, both reset to 1)
// is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module dhcp_option_stream_checker #(
    parameter int RES_DEPTH = dosc_pkg::RES_FIFO_DEPTH   // 2 or more
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [dosc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                           i_cfg_data,
    // byte input channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_end_of_buffer,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_record_kind,
    output logic [7:0]                          o_option_tag,
    output logic [7:0]                          o_option_length,
    output logic [31:0]                         o_first_word,
    output logic                                o_format_known,
    output logic                                o_is_parameter,
    output logic [7:0]                          o_overload_mode,
    output logic [2:0]                          o_status,
    output logic                                o_last_result
);
    import dosc_pkg::*;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,   // buffer start, overload capture cleared here if enabled
        PH_TAG   = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_VAL   = 5'b01000,
        PH_DRAIN = 5'b10000    // swallow until end of buffer
    } t_phase;

    // config
    logic        r_cap;
    logic        r_ven;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_eob;

    // parse state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_word, n_word;
    logic        r_swv, n_swv;
    logic [7:0]  r_ovl, n_ovl;

    // datapath
    logic        w_fire;
    logic        w_space2;
    logic        w_at_tag;
    logic [7:0]  w_tag_cur;
    t_fmt        w_fmt;
    logic [7:0]  w_len_new;
    logic [31:0] w_word_new;
    logic        w_swv_new;
    logic [7:0]  w_left_dec;
    logic [7:0]  w_v;
    logic [7:0]  w_occ;
    logic [7:0]  w_mask;
    t_status     w_chk_st;
    logic        w_chk_ovl_set;
    logic        w_complete;
    logic        w_r0_vld, w_r0_kind, w_r0_opt, w_r0_last;
    t_status     w_r0_st;
    logic        w_r1_vld;
    t_result     w_res0, w_res1, w_out;
    logic [1:0]  w_push;

    function automatic t_result f_make(input logic kind, input logic opt, input t_status st,
                                       input logic last, input logic [7:0] tag,
                                       input logic [7:0] len, input logic [31:0] word,
                                       input t_fmt fmt, input logic [7:0] ovl);
        t_result r;
        r.record_kind   = kind;
        r.option_tag    = opt ? tag  : '0;
        r.option_length = opt ? len  : '0;
        r.first_word    = opt ? word : '0;
        r.format_known  = opt & fmt.known;
        r.is_parameter  = opt & fmt.alert;
        r.overload_mode = ovl;
        r.status        = st;
        r.last_result   = last;
        return r;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 1'b1;
            r_ven <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPTURE_OVERLOAD: r_cap <= i_cfg_data;
                CFG_VALIDATE_ENABLE:  r_ven <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    // ---------------- input register ----------------
    // A held byte is parsed once the queue has room for two results.
    assign w_fire  = r_in_vld && w_space2;
    assign o_ready = !r_in_vld || w_space2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_eob  <= i_end_of_buffer;
        end
    end

    // ---------------- value update and option check ----------------
    assign w_at_tag   = (r_phase == PH_START) || (r_phase == PH_TAG);
    assign w_tag_cur  = w_at_tag ? r_in_byte : r_tag;
    assign w_fmt      = f_fmt_lookup(w_tag_cur);
    assign w_left_dec = r_left - 8'd1;

    always_comb begin
        w_len_new  = (r_phase == PH_LEN) ? r_in_byte : r_len;
        w_word_new = r_word;
        w_swv_new  = r_swv;
        if (r_phase == PH_VAL) begin
            // only the first four value bytes enter the word
            if ((r_len - r_left) < 8'(VALUE_BYTES)) begin
                w_word_new = {r_word[23:0], r_in_byte};
            end
            if (w_fmt.sw && (r_in_byte > 8'd1)) begin
                w_swv_new = 1'b1;
            end
        end
    end

    always_comb begin
        w_v           = w_word_new[7:0];
        w_occ         = w_len_new >> w_fmt.shift;
        w_chk_st      = ST_OK;
        w_chk_ovl_set = 1'b0;
        unique case (w_fmt.shift)
            SH_U1:   w_mask = 8'h00;
            SH_U2:   w_mask = 8'h01;
            SH_U4:   w_mask = 8'h03;
            SH_U8:   w_mask = 8'h07;
            default: w_mask = 8'h00;
        endcase
        // overload capture runs ahead of, and independent of, format checking
        if ((r_tag == TAG_OVERLOAD) && r_cap) begin
            if (w_len_new != 8'd1) begin
                w_chk_st = ST_BAD_OVERLOAD_LEN;
            end else begin
                w_chk_ovl_set = 1'b1;
            end
        end
        if ((w_chk_st == ST_OK) && r_ven && w_fmt.known) begin
            if (((w_len_new & w_mask) != 8'd0) || (w_occ < {5'd0, w_fmt.lo}) ||
                (w_fmt.hi_one && (w_occ > 8'd1)) || (w_fmt.sw && w_swv_new)) begin
                w_chk_st = ST_BAD_FORMAT;
            end else if (w_fmt.alert &&
                         (((r_tag == TAG_OVERLOAD) &&
                           ((w_v < 8'd1) || (w_v > OVERLOAD_MAX))) ||
                          ((r_tag == TAG_MSG_TYPE) &&
                           ((w_v < 8'd1) || (w_v > MSG_TYPE_MAX))))) begin
                w_chk_st = ST_PARAM_RANGE;
            end
        end
    end

    // ---------------- parse step ----------------
    always_comb begin
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_len      = r_len;
        n_left     = r_left;
        n_word     = r_word;
        n_swv      = r_swv;
        n_ovl      = r_ovl;
        w_complete = 1'b0;
        w_r0_vld   = 1'b0;
        w_r0_kind  = 1'b1;
        w_r0_opt   = 1'b0;
        w_r0_st    = ST_OK;
        w_r0_last  = 1'b1;
        w_r1_vld   = 1'b0;

        unique case (r_phase)
            PH_START, PH_TAG: begin
                if ((r_phase == PH_START) && r_cap) begin
                    n_ovl = '0;
                end
                n_phase = PH_TAG;
                if (r_in_byte == TAG_PAD) begin
                    if (r_in_eob) begin
                        n_phase  = PH_START;
                        w_r0_vld = 1'b1;
                        w_r0_st  = ST_NO_END;
                    end
                end else if (r_in_byte == TAG_END) begin
                    n_phase  = r_in_eob ? PH_START : PH_DRAIN;
                    w_r0_vld = 1'b1;
                end else begin
                    n_tag  = r_in_byte;
                    n_len  = '0;
                    n_left = '0;
                    n_word = '0;
                    n_swv  = 1'b0;
                    if (r_in_eob) begin
                        n_phase  = PH_START;
                        w_r0_vld = 1'b1;
                        w_r0_opt = 1'b1;
                        w_r0_st  = ST_TRUNCATED;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                n_len  = r_in_byte;
                n_left = r_in_byte;
                if (r_in_byte == 8'd0) begin
                    w_complete = 1'b1;
                end else if (r_in_eob) begin
                    n_phase  = PH_START;
                    w_r0_vld = 1'b1;
                    w_r0_opt = 1'b1;
                    w_r0_st  = ST_TRUNCATED;
                end else begin
                    n_phase = PH_VAL;
                end
            end
            PH_VAL: begin
                n_word = w_word_new;
                n_swv  = w_swv_new;
                n_left = w_left_dec;
                if (w_left_dec == 8'd0) begin
                    w_complete = 1'b1;
                end else if (r_in_eob) begin
                    n_phase  = PH_START;
                    w_r0_vld = 1'b1;
                    w_r0_opt = 1'b1;
                    w_r0_st  = ST_TRUNCATED;
                end
            end
            PH_DRAIN: begin
                if (r_in_eob) begin
                    n_phase = PH_START;
                end
            end
            default: begin
                n_phase = PH_START;
            end
        endcase

        if (w_complete) begin
            if (w_chk_ovl_set) begin
                n_ovl = w_v;
            end
            w_r0_vld = 1'b1;
            w_r0_opt = 1'b1;
            if (w_chk_st != ST_OK) begin
                // failing option closes the buffer with its own record
                w_r0_st = w_chk_st;
                n_phase = r_in_eob ? PH_START : PH_DRAIN;
            end else begin
                w_r0_kind = 1'b0;
                w_r0_last = 1'b0;
                if (r_in_eob) begin
                    w_r1_vld = 1'b1;   // buffer ended without end tag
                    n_phase  = PH_START;
                end else begin
                    n_phase = PH_TAG;
                end
            end
        end

        w_res0 = f_make(w_r0_kind, w_r0_opt, w_r0_st, w_r0_last,
                        n_tag, n_len, n_word, w_fmt, n_ovl);
        w_res1 = f_make(1'b1, 1'b0, ST_NO_END, 1'b1,
                        n_tag, n_len, n_word, w_fmt, n_ovl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_ovl   <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_ovl   <= n_ovl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_tag  <= n_tag;
            r_len  <= n_len;
            r_left <= n_left;
            r_word <= n_word;
            r_swv  <= n_swv;
        end
    end

    // ---------------- result queue ----------------
    assign w_push = {w_r1_vld, w_r0_vld} & {2{w_fire}};

    dosc_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data0  (w_res0),
        .i_data1  (w_res1),
        .o_space2 (w_space2),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (w_out)
    );

    assign o_record_kind   = w_out.record_kind;
    assign o_option_tag    = w_out.option_tag;
    assign o_option_length = w_out.option_length;
    assign o_first_word    = w_out.first_word;
    assign o_format_known  = w_out.format_known;
    assign o_is_parameter  = w_out.is_parameter;
    assign o_overload_mode = w_out.overload_mode;
    assign o_status        = w_out.status;
    assign o_last_result   = w_out.last_result;

    // ---------------- assertions ----------------
    // the last byte of a buffer always returns the parser to buffer start
    a_eob_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_eob |=> (r_phase == PH_START))
        else $error("parser not at buffer start after last byte");

    // an option record is never the final record and always carries ok status
    a_rec_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_record_kind |-> !o_last_result && (o_status == ST_OK))
        else $error("option record flagged last or failing");

    // a second result only follows a passing option record
    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_r1_vld |-> w_r0_vld && !w_r0_kind && w_r0_last == 1'b0)
        else $error("status record without preceding option record");

    // a held byte waits for queue room and is not overwritten
    a_hold_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_space2 |=> r_in_vld && $stable(r_in_byte))
        else $error("input byte lost while result queue full");

endmodule

`default_nettype wire
